@@ design/drx_pkg.sv @@
// Shared types and constants for the data run extent decoder.
`default_nettype none

package drx_pkg;

  localparam int unsigned MaxFieldBytes = 8;

  typedef enum logic [1:0] {
    PhIdle   = 2'd0,
    PhHeader = 2'd1,
    PhLength = 2'd2,
    PhOffset = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KindExtent  = 2'd0,
    KindEnd     = 2'd1,
    KindOverrun = 2'd2,
    KindSize    = 2'd3
  } kind_e;

  localparam logic [3:0] MaxFieldNib = 4'(MaxFieldBytes);

endpackage

`default_nettype wire

@@ design/data_run_extent_decoder.sv @@
// Data run (mapping pairs) decoder: one run list byte per request, one extent per run.
// Path from input request to result: input register, then result register.
// Throughput: one byte per cycle; the single pass holds one 64-bit add per running sum.
// A full result register stalls the pass only while the output is not taken.
// Reset: asynchronous, active low; decoder idles until a byte with list start arrives.
// All running sums and counters clear on reset.
`default_nettype none

module data_run_extent_decoder (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [71:0]  s_axis_tdata_i,  // data_byte[7:0], start_vcn[71:8]
  input  wire logic         s_axis_tuser_i,  // list_start
  input  wire logic         s_axis_tlast_i,  // buffer_end
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // run_lcn[63:0], extent_next_vcn[127:64], is_virtual[128],
  // real_clusters[192:129], zero pad[199:193]
  output logic [199:0]      m_axis_tdata_o,
  output logic [1:0]        m_axis_tuser_o   // result_kind
);

  // input register
  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_start_q;
  logic [63:0] in_vcn_q;
  logic        in_last_q;

  // decoder state
  drx_pkg::phase_e phase_q, phase_d;
  logic [3:0]  len_left_q, len_left_d;
  logic [3:0]  off_left_q, off_left_d;
  logic [2:0]  pos_q, pos_d;
  logic [63:0] len_acc_q, len_acc_d;
  logic [63:0] off_acc_q, off_acc_d;
  logic [63:0] clus_q, clus_d;
  logic [63:0] vcn_q, vcn_d;
  logic [63:0] total_q, total_d;

  // result register
  logic             out_vld_q;
  drx_pkg::kind_e   out_kind_q;
  logic [63:0]      out_lcn_q;
  logic [63:0]      out_vcn_q;
  logic             out_virt_q;
  logic [63:0]      out_total_q;

  logic             proc_go;
  logic             step;
  logic             res_vld;
  drx_pkg::kind_e   res_kind;
  logic [63:0]      res_lcn;
  logic [63:0]      res_vcn;
  logic             res_virt;
  logic [63:0]      res_total;

  assign proc_go         = !out_vld_q || m_axis_tready_i;
  assign step            = in_vld_q && proc_go;
  assign s_axis_tready_o = !in_vld_q || proc_go;

  always_comb begin
    logic [63:0] clus_b, vcn_b, total_b;
    logic [63:0] len_new, off_new, sext;
    logic [3:0]  lsz, osz;
    logic [3:0]  len_dec, off_dec;
    logic        finish;
    logic [63:0] fin_len, fin_off;
    logic        virt;

    clus_b  = in_start_q ? 64'd0 : clus_q;
    vcn_b   = in_start_q ? in_vcn_q : vcn_q;
    total_b = in_start_q ? 64'd0 : total_q;
    lsz     = in_byte_q[3:0];
    osz     = in_byte_q[7:4];
    len_dec = len_left_q - 4'd1;
    off_dec = off_left_q - 4'd1;

    len_new = len_acc_q;
    off_new = off_acc_q;
    sext    = '0;
    for (int j = 0; j < 8; j++) begin
      if (pos_q == 3'(j)) begin
        len_new[j*8 +: 8] = len_acc_q[j*8 +: 8] | in_byte_q;
        off_new[j*8 +: 8] = off_acc_q[j*8 +: 8] | in_byte_q;
      end
      if (3'(j) > pos_q && in_byte_q[7]) begin
        sext[j*8 +: 8] = 8'hFF;
      end
    end

    phase_d    = phase_q;
    len_left_d = len_left_q;
    off_left_d = off_left_q;
    pos_d      = pos_q;
    len_acc_d  = len_acc_q;
    off_acc_d  = off_acc_q;
    clus_d     = clus_b;
    vcn_d      = vcn_b;
    total_d    = total_b;
    res_vld    = 1'b0;
    res_kind   = drx_pkg::KindEnd;
    finish     = 1'b0;
    fin_len    = len_acc_q;
    fin_off    = off_acc_q;

    if (in_start_q || phase_q == drx_pkg::PhHeader) begin
      if (in_byte_q == 8'h00) begin
        res_vld  = 1'b1;
        res_kind = drx_pkg::KindEnd;
        phase_d  = drx_pkg::PhIdle;
      end else if (in_last_q) begin
        res_vld  = 1'b1;
        res_kind = drx_pkg::KindOverrun;
        phase_d  = drx_pkg::PhIdle;
      end else if (lsz > drx_pkg::MaxFieldNib || osz > drx_pkg::MaxFieldNib) begin
        res_vld  = 1'b1;
        res_kind = drx_pkg::KindSize;
        phase_d  = drx_pkg::PhIdle;
      end else begin
        len_left_d = lsz;
        off_left_d = osz;
        pos_d      = 3'd0;
        len_acc_d  = '0;
        off_acc_d  = '0;
        phase_d    = (lsz != 4'd0) ? drx_pkg::PhLength : drx_pkg::PhOffset;
      end
    end else begin
      case (phase_q)
        drx_pkg::PhLength: begin
          if (in_last_q) begin
            res_vld  = 1'b1;
            res_kind = drx_pkg::KindOverrun;
            phase_d  = drx_pkg::PhIdle;
          end else begin
            len_acc_d  = len_new;
            len_left_d = len_dec;
            pos_d      = pos_q + 3'd1;
            fin_len    = len_new;
            if (len_dec == 4'd0) begin
              pos_d = 3'd0;
              if (off_left_q == 4'd0) begin
                finish = 1'b1;
              end else begin
                phase_d = drx_pkg::PhOffset;
              end
            end
          end
        end
        drx_pkg::PhOffset: begin
          if (in_last_q) begin
            res_vld  = 1'b1;
            res_kind = drx_pkg::KindOverrun;
            phase_d  = drx_pkg::PhIdle;
          end else begin
            off_acc_d  = off_new;
            off_left_d = off_dec;
            pos_d      = pos_q + 3'd1;
            if (off_dec == 4'd0) begin
              off_acc_d = off_new | sext;
              fin_off   = off_new | sext;
              pos_d     = 3'd0;
              finish    = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    virt = (fin_off == 64'd0);
    if (finish) begin
      clus_d   = clus_q + fin_off;
      vcn_d    = vcn_q + fin_len;
      total_d  = virt ? total_q : total_q + fin_len;
      res_vld  = 1'b1;
      res_kind = drx_pkg::KindExtent;
      phase_d  = drx_pkg::PhHeader;
    end

    res_lcn   = clus_d;
    res_vcn   = vcn_d;
    res_total = total_d;
    res_virt  = finish && virt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      phase_q    <= drx_pkg::PhIdle;
      len_left_q <= '0;
      off_left_q <= '0;
      pos_q      <= '0;
      len_acc_q  <= '0;
      off_acc_q  <= '0;
      clus_q     <= '0;
      vcn_q      <= '0;
      total_q    <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_vld_q <= 1'b1;
      end else if (proc_go) begin
        in_vld_q <= 1'b0;
      end
      if (step) begin
        phase_q    <= phase_d;
        len_left_q <= len_left_d;
        off_left_q <= off_left_d;
        pos_q      <= pos_d;
        len_acc_q  <= len_acc_d;
        off_acc_q  <= off_acc_d;
        clus_q     <= clus_d;
        vcn_q      <= vcn_d;
        total_q    <= total_d;
      end
      if (proc_go) begin
        out_vld_q <= step && res_vld;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q  <= s_axis_tdata_i[7:0];
      in_vcn_q   <= s_axis_tdata_i[71:8];
      in_start_q <= s_axis_tuser_i;
      in_last_q  <= s_axis_tlast_i;
    end
    if (step && res_vld) begin
      out_kind_q  <= res_kind;
      out_lcn_q   <= res_lcn;
      out_vcn_q   <= res_vcn;
      out_virt_q  <= res_virt;
      out_total_q <= res_total;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tdata_o  = {7'd0, out_total_q, out_virt_q, out_vcn_q, out_lcn_q};

  a_len_phase_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == drx_pkg::PhLength |-> len_left_q != 4'd0)
    else $error("length phase with no length bytes left");

  a_field_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_left_q <= drx_pkg::MaxFieldNib && off_left_q <= drx_pkg::MaxFieldNib)
    else $error("field byte count above limit");

  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && phase_q == drx_pkg::PhIdle && !in_start_q) |=> !out_vld_q)
    else $error("idle byte without list start produced a result");

endmodule

`default_nettype wire
